@@ rtl/core/prm_pkg.sv @@
package prm_pkg;

    // Window geometry and sample format
    localparam int WINDOW      = 7;
    localparam int SAMPLE_BITS = 16;
    localparam int CHANNELS    = 3;

    // Rank picked from the sorted window (upper median for even windows)
    localparam int RANK_TARGET = WINDOW / 2;

    // Counter widths
    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);

    // Stream data width, padded to whole bytes
    localparam int PAYLOAD_W = CHANNELS * SAMPLE_BITS;
    localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] chan_vec_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RANK,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;   // shift new sample into windows, clear index
        logic rank_en;   // rank one candidate per channel
        logic load_out;  // move medians into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic rank_last; // current candidate is the last window entry
    } status_t;

endpackage

@@ rtl/core/pose_running_median_core.sv @@
// Running median over the last WINDOW pose samples, per channel.
// A new request is accepted only while idle, after the previous medians have
// moved into the output register; one window entry is ranked per cycle against
// all others by a comparator row per channel.
// Reset (rst_n low, asynchronous): windows cleared to zero, no result pending.
module pose_running_median_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // sample_x, sample_y, sample_heading
    input  logic [prm_pkg::TDATA_W-1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // median_x, median_y, median_heading
    output logic [prm_pkg::TDATA_W-1:0] m_axis_tdata
);
    import prm_pkg::*;

    cmd_t      cmd;
    status_t   status;
    chan_vec_t sample_in;
    chan_vec_t median_out;

    assign sample_in = s_axis_tdata[PAYLOAD_W-1:0];

    // Result packing, zero pad to byte boundary
    always_comb
    begin
        m_axis_tdata                = '0;
        m_axis_tdata[PAYLOAD_W-1:0] = median_out;
    end

    prm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    prm_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sample_in  (sample_in),
        .median_out (median_out),
        .status     (status)
    );

endmodule

@@ rtl/core/prm_ctrl.sv @@
module prm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output prm_pkg::cmd_t    cmd,
    input  prm_pkg::status_t status
);
    import prm_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // Output register may be refilled when empty or being drained
    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RANK;
                end
            end
            ST_RANK:
            begin
                if (status.rank_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready     = 1'b0;
        cmd.load_in  = 1'b0;
        cmd.rank_en  = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_RANK:
            begin
                cmd.rank_en = 1'b1;
            end
            ST_DONE:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/core/prm_dpath.sv @@
module prm_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  prm_pkg::cmd_t       cmd,
    input  prm_pkg::chan_vec_t  sample_in,
    output prm_pkg::chan_vec_t  median_out,
    output prm_pkg::status_t    status
);
    import prm_pkg::*;

    sample_t          win_reg [CHANNELS][WINDOW];
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    sample_t          med_reg [CHANNELS];
    sample_t          out_reg [CHANNELS];
    sample_t          cand    [CHANNELS];
    logic [CNT_W-1:0] rank    [CHANNELS];
    logic             hit     [CHANNELS];

    assign status.rank_last = (idx_reg == IDX_W'(WINDOW - 1));

    // Candidate index: cleared on a new sample, steps while ranking
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load_in)
        begin
            idx_next = '0;
        end
        else if (cmd.rank_en && !status.rank_last)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    // Rank of the current candidate: entries below it, ties broken by position
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            cand[c] = win_reg[c][idx_reg];
            rank[c] = '0;
            for (int j = 0; j < WINDOW; j++)
            begin
                if ((win_reg[c][j] < cand[c]) ||
                    ((win_reg[c][j] == cand[c]) && (IDX_W'(j) < idx_reg)))
                begin
                    rank[c] = rank[c] + CNT_W'(1);
                end
            end
            hit[c] = (rank[c] == CNT_W'(RANK_TARGET));
        end
    end

    // Sample windows, newest in entry 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                for (int i = 0; i < WINDOW; i++)
                begin
                    win_reg[c][i] <= '0;
                end
            end
            idx_reg <= '0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    win_reg[c][0] <= sample_t'(sample_in[c]);
                    for (int i = 1; i < WINDOW; i++)
                    begin
                        win_reg[c][i] <= win_reg[c][i-1];
                    end
                end
            end
            idx_reg <= idx_next;
        end
    end

    // Median capture and output register
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (cmd.rank_en && hit[c])
            begin
                med_reg[c] <= cand[c];
            end
            if (cmd.load_out)
            begin
                out_reg[c] <= med_reg[c];
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            median_out[c] = out_reg[c];
        end
    end

endmodule

@@ sim/pose_median_checker.sv @@
`timescale 1ns / 1ps

module pose_median_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    // sample_x, sample_y, sample_heading
    input  logic [prm_pkg::TDATA_W-1:0] s_axis_tdata,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // median_x, median_y, median_heading
    input  logic [prm_pkg::TDATA_W-1:0] m_axis_tdata,
    output int                          mismatches,
    output int                          pending_medians
);

    import prm_pkg::*;

    // Own copy of the sliding windows, entry 0 newest
    sample_t   pose_window [CHANNELS][WINDOW];
    chan_vec_t expected_medians [$];
    chan_vec_t new_pose;
    chan_vec_t got_median;
    chan_vec_t want_median;
    int        ch;
    int        pos;

    // Element of rank WINDOW/2, ties broken by window position
    function automatic sample_t window_median(input int chan);
        int      rank;
        sample_t pick;
        pick = pose_window[chan][0];
        for (int i = 0; i < WINDOW; i++)
        begin
            rank = 0;
            for (int j = 0; j < WINDOW; j++)
            begin
                if (pose_window[chan][j] < pose_window[chan][i] ||
                    (pose_window[chan][j] == pose_window[chan][i] && j < i))
                    rank++;
            end
            if (rank == RANK_TARGET)
                pick = pose_window[chan][i];
        end
        return pick;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (ch = 0; ch < CHANNELS; ch++)
                for (pos = 0; pos < WINDOW; pos++)
                    pose_window[ch][pos] = '0;
            expected_medians.delete();
            mismatches      = 0;
            pending_medians = 0;
        end
        else
        begin
            // Returned result against the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_median = m_axis_tdata[PAYLOAD_W-1:0];
                if (expected_medians.size() == 0)
                begin
                    $display("%0t: result %h with no request outstanding", $time, got_median);
                    mismatches++;
                end
                else
                begin
                    want_median = expected_medians.pop_front();
                    for (ch = 0; ch < CHANNELS; ch++)
                    begin
                        if (got_median[ch] !== want_median[ch])
                        begin
                            $display("%0t: median field %0d (x, y, heading) expected %h got %h",
                                     $time, ch, want_median[ch], got_median[ch]);
                            mismatches++;
                        end
                    end
                end
            end

            // Accepted request: shift every window, predict the medians
            if (s_axis_tvalid && s_axis_tready)
            begin
                new_pose = s_axis_tdata[PAYLOAD_W-1:0];
                for (ch = 0; ch < CHANNELS; ch++)
                begin
                    for (pos = WINDOW - 1; pos > 0; pos--)
                        pose_window[ch][pos] = pose_window[ch][pos-1];
                    pose_window[ch][0] = new_pose[ch];
                    want_median[ch]    = window_median(ch);
                end
                expected_medians.push_back(want_median);
            end

            pending_medians = expected_medians.size();
        end
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

    import prm_pkg::*;

    localparam int RANDOM_POSES = 1850;
    localparam int DRAIN_AT     = 900;
    localparam int HOLD_AT      = 4000;
    localparam int HOLD_LEN     = 500;
    localparam int SETTLE       = WINDOW + 8;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;

    int      mismatches;
    int      pending_medians;
    int      n;
    int      rx_cycles;
    int      stall_left;
    int      hold_left;
    bit      rx_calm;
    sample_t last_x;
    sample_t last_y;
    sample_t last_h;

    pose_running_median_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pose_median_checker median_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .mismatches      (mismatches),
        .pending_medians (pending_medians)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #30_000_000;
        $display("FAILURE");
        $finish;
    end

    // Mostly back to back, sometimes short gaps, now and then a long one
    function automatic int sender_gap(input bit calm);
        int p;
        int gap;
        p = $urandom_range(0, 99);
        if (calm || p < 60)
            gap = 0;
        else if (p < 92)
            gap = $urandom_range(1, 4);
        else
            gap = $urandom_range(12, 60);
        return gap;
    endfunction

    // Coordinate mix: raw noise, clustered duplicates, extremes, slow drift
    function automatic sample_t random_coord(input sample_t prev);
        int      p;
        sample_t v;
        p = $urandom_range(0, 99);
        if (p < 45)
            v = sample_t'($urandom);
        else if (p < 65)
            v = sample_t'(int'($urandom_range(0, 4)) - 2);
        else if (p < 75)
        begin
            case ($urandom_range(0, 3))
                0:       v = 16'h7fff;
                1:       v = 16'h8000;
                2:       v = 16'hffff;
                default: v = 16'h0000;
            endcase
        end
        else
            v = prev + sample_t'(int'($urandom_range(0, 64)) - 32);
        return v;
    endfunction

    // One pose request, held until accepted
    task automatic send_pose(input sample_t x, input sample_t y, input sample_t h,
                             input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'({h, y, x});
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        last_x = x;
        last_y = y;
        last_h = h;
    endtask

    // Result side: random stalls, calm stretches, one long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        rx_cycles     = 0;
        stall_left    = 0;
        hold_left     = 0;
        rx_calm       = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            rx_cycles++;
            if (rx_cycles % 1000 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            if (rx_cycles == HOLD_AT)
                hold_left = HOLD_LEN;
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 3) == 0)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                             : $urandom_range(1, 3);
            end
        end
    end

    // Request side and verdict
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        last_x        = '0;
        last_y        = '0;
        last_h        = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Warm-up against the reset zeros, with extremes and bit patterns
        send_pose(16'sd16, -16'sd16, 16'sd0, 0);
        send_pose(16'h7fff, 16'h8000, 16'h7fff, 0);
        send_pose(16'h7fff, 16'h8000, 16'h8000, 1);
        send_pose(16'h8000, 16'h7fff, 16'h0001, 0);
        send_pose(16'hffff, 16'h0000, 16'hffff, 3);
        send_pose(16'h5555, 16'haaaa, 16'h7fff, 0);
        send_pose(16'haaaa, 16'h5555, 16'h8000, 0);

        // Equal values keep their multiplicity
        repeat (4) send_pose(16'sd100, -16'sd100, 16'sd5, 0);
        send_pose(16'sd100, -16'sd100, 16'sd6, 0);

        // Whole window at the extremes
        repeat (7) send_pose(16'h7fff, 16'h8000, 16'h7fff, 0);
        repeat (3) send_pose(16'h8000, 16'h7fff, 16'h8000, 2);

        for (n = 0; n < RANDOM_POSES; n++)
        begin
            // Let the pipe run dry once mid-run
            if (n == DRAIN_AT)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                while (pending_medians != 0)
                    @(negedge clk);
            end
            send_pose(random_coord(last_x), random_coord(last_y), random_coord(last_h),
                      sender_gap(((n / 150) % 3) == 2));
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_medians != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
